FILE: hw/rtl/bucketed_hash_table_core_assert.svh
// Assertion macros used by the bucketed hash table core.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef BUCKETED_HASH_TABLE_CORE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH

// Plain invariant, checked at every clock edge outside reset.
`define BHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BHT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BHT_ASSERT_ALWAYS(label, prop, msg)
`define BHT_ASSERT_IMPL(label, ante, cons, msg)
`define BHT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/bht_pkg.sv
`timescale 1ns / 1ps

package bht_pkg;

    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // key bits folded into the remainder per cycle by the modulo unit
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_LOOKUP
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic val_we;
    } mem_ctrl_t;

endpackage

FILE: hw/rtl/bht_mod.sv
`timescale 1ns / 1ps

// key mod BUCKETS: a bit slice for power-of-two counts, otherwise a
// digit-serial remainder fold, MOD_DIGIT_W bits per cycle.
module bht_mod
    import bht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KEY_W-1:0]           key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BW = $clog2(BUCKETS);

    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2

        assign done   = start;
        assign bucket = key[BW-1:0];

    end else begin : g_iter

        localparam int PAD_W = MOD_STEPS * MOD_DIGIT_W;
        localparam int CNT_W = $clog2(MOD_STEPS + 1);
        localparam logic [BW:0] MODULUS = (BW + 1)'(BUCKETS);

        logic             busy_reg, busy_next;
        logic [CNT_W-1:0] cnt_reg, cnt_next;
        logic [PAD_W-1:0] sh_reg, sh_next;
        logic [BW-1:0]    rem_reg, rem_next;
        logic [BW:0]      part;

        always_comb
        begin
            busy_next = busy_reg;
            cnt_next  = cnt_reg;
            sh_next   = sh_reg;
            rem_next  = rem_reg;
            part      = '0;
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(MOD_STEPS);
                sh_next   = PAD_W'(key);
                rem_next  = '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    // rem = (2*rem + bit) mod BUCKETS, msb first
                    for (int i = 0; i < MOD_DIGIT_W; i++)
                    begin
                        part = {rem_next, sh_next[PAD_W-1]};
                        if (part >= MODULUS)
                        begin
                            part = part - MODULUS;
                        end
                        rem_next = part[BW-1:0];
                        sh_next  = {sh_next[PAD_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end

        always_ff @(posedge clk)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end

        assign done   = busy_reg && (cnt_reg == '0);
        assign bucket = rem_reg;

    end

endmodule

FILE: hw/rtl/bht_mem.sv
`timescale 1ns / 1ps

// Bucket row store (valid marks + keys, one row per bucket, registered read)
// and the per-slot value store.
module bht_mem
    import bht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic                             clk,
    input  mem_ctrl_t                        ctrl,
    input  logic [$clog2(BUCKETS)-1:0]       rd_addr,
    input  logic [$clog2(BUCKETS)-1:0]       tag_addr,
    input  logic [WAYS*(KEY_W+1)-1:0]        tag_row,
    input  logic [$clog2(BUCKETS*WAYS)-1:0]  val_addr,
    input  logic [VALUE_W-1:0]               val_data,
    output logic [WAYS*(KEY_W+1)-1:0]        rd_row
);

    localparam int ROW_W = WAYS * (KEY_W + 1);
    localparam int SLOTS = BUCKETS * WAYS;

    logic [ROW_W-1:0]   tag_mem [BUCKETS];
    logic [VALUE_W-1:0] val_mem [SLOTS];
    logic [ROW_W-1:0]   rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.tag_we)
        begin
            tag_mem[tag_addr] <= tag_row;
        end
        if (ctrl.rd_en)
        begin
            rd_row_reg <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.val_we)
        begin
            val_mem[val_addr] <= val_data;
        end
    end

    assign rd_row = rd_row_reg;

endmodule

FILE: hw/rtl/bucketed_hash_table_core.sv
`timescale 1ns / 1ps
// Bucketed hash table: each request inserts/replaces or removes a 31-bit key
// (with a 32-bit value) in bucket key mod BUCKETS, which holds WAYS slots, and
// returns one result (status, table_empty) per request in request order.
// When BUCKETS is a power of two a request is one synchronous read of the
// bucket row, then the parallel compare across the ways and the write-back.
// For other bucket counts the key is first reduced by a fold unit that takes
// 8 key bits per cycle.
// One request is in flight at a time; the result sits in an output register,
// so the next request is taken while a result still waits for transfer.
// After reset the block runs a clearing pass over every row of the row store,
// with in_stall held high, before the first request is taken.

`include "bucketed_hash_table_core_assert.svh"

module bucketed_hash_table_core
    import bht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                table_empty
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int SA_W  = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int ROW_W = WAYS * (KEY_W + 1);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

    // sequencer
    state_t state_reg, state_next;

    // request held for the whole operation
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [BW-1:0]      bucket_reg, bucket_next;

    // clearing pass pointer and live entry count
    logic [BW-1:0] clr_reg, clr_next;
    logic [CW-1:0] count_reg, count_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic    empty_reg;

    // handshake / control
    logic      accept;
    logic      out_free;
    logic      commit;
    mem_ctrl_t ctrl;

    // modulo unit
    logic          mod_done;
    logic [BW-1:0] mod_bucket;

    // row store ports
    logic [BW-1:0]      tag_addr;
    logic [ROW_W-1:0]   tag_row;
    logic [ROW_W-1:0]   rd_row;
    logic [SA_W-1:0]    val_addr;

    // row fields and match results
    logic [WAYS-1:0]  row_valid;
    logic [KEY_W-1:0] row_key [WAYS];
    logic [WAYS-1:0]  new_valid;
    logic [KEY_W-1:0] new_key [WAYS];
    logic [ROW_W-1:0] new_row;
    logic             hit, free;
    logic [WW-1:0]    hit_way, free_way, val_way;

    bht_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .key    (key),
        .done   (mod_done),
        .bucket (mod_bucket)
    );

    bht_mem #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_mem (
        .clk      (clk),
        .ctrl     (ctrl),
        .rd_addr  (mod_bucket),
        .tag_addr (tag_addr),
        .tag_row  (tag_row),
        .val_addr (val_addr),
        .val_data (value_reg),
        .rd_row   (rd_row)
    );

    // Row layout: {key[WAYS-1] .. key[0], valid[WAYS-1:0]}
    always_comb
    begin
        row_valid = rd_row[WAYS-1:0];
        for (int w = 0; w < WAYS; w++)
        begin
            row_key[w] = rd_row[WAYS + w*KEY_W +: KEY_W];
        end
    end

    // Parallel compare across the ways: first valid matching way,
    // first free way.
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_valid[w])
            begin
                if (!hit && (row_key[w] == key_reg))
                begin
                    hit     = 1'b1;
                    hit_way = WW'(w);
                end
            end
            else if (!free)
            begin
                free     = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    // Modified row: fill the free way on insert, drop the hit way on remove.
    // Only written back when the operation actually changes the row.
    always_comb
    begin
        new_valid = row_valid;
        for (int w = 0; w < WAYS; w++)
        begin
            new_key[w] = row_key[w];
        end
        if (cmd_reg == CMD_INSERT)
        begin
            new_valid[free_way] = 1'b1;
            new_key[free_way]   = key_reg;
        end
        else
        begin
            new_valid[hit_way] = 1'b0;
        end
        new_row[WAYS-1:0] = new_valid;
        for (int w = 0; w < WAYS; w++)
        begin
            new_row[WAYS + w*KEY_W +: KEY_W] = new_key[w];
        end
    end

    // Status and entry count for the request in LOOKUP
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        if (cmd_reg == CMD_INSERT)
        begin
            if (hit)
            begin
                status_next = ST_REPLACED;
            end
            else if (free)
            begin
                status_next = ST_INSERTED;
                if (commit)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (hit)
            begin
                status_next = ST_REMOVED;
                if (commit)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_BUCKET)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mod_done ? S_LOOKUP : S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (mod_done)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctrl.rd_en  = 1'b0;
        ctrl.tag_we = 1'b0;
        ctrl.val_we = 1'b0;
        commit      = 1'b0;
        tag_addr    = bucket_reg;
        tag_row     = new_row;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.tag_we = 1'b1;
                tag_addr    = clr_reg;
                tag_row     = '0;
            end
            S_IDLE:
            begin
                in_stall   = 1'b0;
                ctrl.rd_en = in_valid && mod_done;
            end
            S_DIVIDE:
            begin
                ctrl.rd_en = mod_done;
            end
            S_LOOKUP:
            begin
                commit      = out_free;
                ctrl.tag_we = out_free
                    && (((cmd_reg == CMD_INSERT) && !hit && free)
                        || ((cmd_reg == CMD_REMOVE) && hit));
                ctrl.val_we = out_free && (cmd_reg == CMD_INSERT) && (hit || free);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign val_way  = hit ? hit_way : free_way;
    assign val_addr = SA_W'(bucket_reg) * SA_W'(WAYS) + SA_W'(val_way);

    assign bucket_next    = ctrl.rd_en ? mod_bucket : bucket_reg;
    assign clr_next       = (state_reg == S_CLEAR) ? clr_reg + 1'b1 : clr_reg;
    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
        end
        bucket_reg <= bucket_next;
        if (commit)
        begin
            status_reg <= status_next;
            empty_reg  <= (count_next == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign table_empty = empty_reg;

    // Checks
    `BHT_ASSERT_ALWAYS(a_count_range, count_reg <= CW'(SLOTS), "entry count above slot total")
    `BHT_ASSERT_IMPL(a_empty_matches, out_valid_reg, table_empty == (count_reg == '0), "table_empty disagrees with entry count")
    `BHT_ASSERT_NEXT(a_count_on_commit, !commit, $stable(count_reg), "entry count moved without a commit")
    `BHT_ASSERT_ALWAYS(a_no_rd_wr_overlap, !(ctrl.rd_en && ctrl.tag_we), "row read and write in the same cycle")

endmodule
